// File: design/lookahead_row_convolution_unit_assert.svh
// Assertion macros used by the checker file.
`ifndef LOOKAHEAD_ROW_CONVOLUTION_UNIT_ASSERT_SVH
`define LOOKAHEAD_ROW_CONVOLUTION_UNIT_ASSERT_SVH

// Checked only outside reset.
`define LRC_ASSERT_RUN(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Checked at every edge, reset included.
`define LRC_ASSERT_ALL(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

// File: design/lrc_pkg.sv
package lrc_pkg;

   localparam int MAX_TAPS     = 16;
   localparam int MAX_CHANNELS = 64;
   localparam int MAX_BATCH    = 8;
   localparam int SAMPLE_WIDTH = 16;

   localparam int TAP_W   = $clog2(MAX_TAPS);
   localparam int CHAN_W  = $clog2(MAX_CHANNELS);
   localparam int BATCH_W = $clog2(MAX_BATCH);
   localparam int TIME_W  = 16;
   localparam int TAP_ADDR_W  = TAP_W + CHAN_W;
   localparam int HIST_ADDR_W = TAP_W + BATCH_W + CHAN_W;
   localparam int PROD_W = 2 * SAMPLE_WIDTH;
   localparam int ACC_W  = PROD_W + TAP_W;

   localparam logic OP_COEF   = 1'b0;
   localparam logic OP_SAMPLE = 1'b1;

   localparam logic [1:0] REG_TAP_COUNT     = 2'd0;
   localparam logic [1:0] REG_CHANNEL_COUNT = 2'd1;
   localparam logic [1:0] REG_BATCH_COUNT   = 2'd2;

   typedef struct packed {
      logic                           is_coef;
      logic [TAP_W-1:0]               tap_index;
      logic [CHAN_W-1:0]              chan;
      logic signed [SAMPLE_WIDTH-1:0] coef;
      logic signed [SAMPLE_WIDTH-1:0] sample;
      logic [TAP_W-1:0]               ring;
      logic [BATCH_W-1:0]             batch;
      logic [TIME_W-1:0]              time_idx;
      logic                           emit;
      logic [TAP_W-1:0]               k_first;
      logic [TAP_W-1:0]               k_last;
   } cmd_type;

   typedef enum logic [1:0] {
      BK_CLEAR,
      BK_IDLE,
      BK_RUN,
      BK_DONE
   } back_state_type;

endpackage

// File: design/lrc_front.sv
module lrc_front import lrc_pkg::*; (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_write_enable,
   input  logic [1:0]                     csr_index,
   input  logic [6:0]                     csr_write_data,
   input  logic                           accept,
   input  logic                           req_operation,
   input  logic [3:0]                     req_tap_index,
   input  logic [5:0]                     req_coef_channel,
   input  logic signed [SAMPLE_WIDTH-1:0] req_coefficient,
   input  logic signed [SAMPLE_WIDTH-1:0] req_sample,
   input  logic                           req_final_step,
   output cmd_type                        cmd
);

   logic [4:0] tap_count_ff;
   logic [6:0] channel_count_ff;
   logic [3:0] batch_count_ff;
   logic [CHAN_W-1:0]  chan_ff, chan_in;
   logic [BATCH_W-1:0] batch_ff, batch_in;
   logic [TIME_W-1:0]  time_ff, time_in;
   logic [TAP_W-1:0]   ring_ff, ring_in;
   logic [4:0]         seen_ff, seen_in;

   logic [4:0] taps, seen, avail, first, lastk;
   logic [6:0] nc;
   logic [3:0] nb;
   logic [CHAN_W-1:0]  c;
   logic [BATCH_W-1:0] b;
   logic [6:0] c_inc;
   logic [3:0] b_inc;

   always_ff @(posedge clock) begin
      if (reset) begin
         tap_count_ff     <= 5'd16;
         channel_count_ff <= 7'd64;
         batch_count_ff   <= 4'd1;
      end else if (csr_write_enable) begin
         case (csr_index)
            REG_TAP_COUNT:     tap_count_ff     <= csr_write_data[4:0];
            REG_CHANNEL_COUNT: channel_count_ff <= csr_write_data;
            REG_BATCH_COUNT:   batch_count_ff   <= csr_write_data[3:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      taps = (tap_count_ff == 5'd0) ? 5'd1 : (tap_count_ff > 5'd16) ? 5'd16 : tap_count_ff;
      nc = (channel_count_ff == 7'd0) ? 7'd1 :
           (channel_count_ff > 7'd64) ? 7'd64 : channel_count_ff;
      nb = (batch_count_ff == 4'd0) ? 4'd1 : (batch_count_ff > 4'd8) ? 4'd8 : batch_count_ff;
      c = ({1'b0, chan_ff} < nc) ? chan_ff : '0;
      b = ({1'b0, batch_ff} < nb) ? batch_ff : '0;
      seen = (seen_ff >= 5'd16) ? 5'd16 : seen_ff + 5'd1;
      avail = (seen < taps) ? seen : taps;
      first = req_final_step ? avail : taps;
      lastk = req_final_step ? 5'd0 : taps - 5'd1;

      cmd.is_coef   = (req_operation == OP_COEF);
      cmd.tap_index = req_tap_index;
      cmd.chan      = (req_operation == OP_COEF) ? req_coef_channel : c;
      cmd.coef      = req_coefficient;
      cmd.sample    = req_sample;
      cmd.ring      = ring_ff;
      cmd.batch     = b;
      cmd.time_idx  = time_ff;
      cmd.emit      = req_final_step || (seen >= taps);
      cmd.k_first   = 4'(first - 5'd1);
      cmd.k_last    = lastk[3:0];

      c_inc = {1'b0, c} + 7'd1;
      b_inc = {1'b0, b} + 4'd1;
      chan_in = chan_ff;
      batch_in = batch_ff;
      time_in = time_ff;
      ring_in = ring_ff;
      seen_in = seen_ff;
      if (accept && req_operation == OP_SAMPLE) begin
         chan_in = c_inc[CHAN_W-1:0];
         batch_in = b;
         if (c_inc >= nc) begin
            chan_in = '0;
            batch_in = b_inc[BATCH_W-1:0];
            if (b_inc >= nb) begin
               batch_in = '0;
               if (req_final_step) begin
                  time_in = '0;
                  ring_in = '0;
                  seen_in = '0;
               end else begin
                  time_in = time_ff + 16'd1;
                  ring_in = ring_ff + 4'd1;
                  seen_in = seen;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         chan_ff  <= '0;
         batch_ff <= '0;
         time_ff  <= '0;
         ring_ff  <= '0;
         seen_ff  <= '0;
      end else begin
         chan_ff  <= chan_in;
         batch_ff <= batch_in;
         time_ff  <= time_in;
         ring_ff  <= ring_in;
         seen_ff  <= seen_in;
      end
   end

endmodule

// File: design/lrc_queue.sv
module lrc_queue import lrc_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_cmd,
   input  logic    pop,
   output cmd_type head,
   output logic    empty,
   output logic    full
);

   cmd_type    entry_ff [2];
   logic       wr_ptr_ff, rd_ptr_ff;
   logic [1:0] count_ff;

   assign head  = entry_ff[rd_ptr_ff];
   assign empty = (count_ff == 2'd0);
   assign full  = (count_ff == 2'd2);

   always_ff @(posedge clock) begin
      if (push) entry_ff[wr_ptr_ff] <= push_cmd;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (push) wr_ptr_ff <= ~wr_ptr_ff;
         if (pop)  rd_ptr_ff <= ~rd_ptr_ff;
         count_ff <= count_ff + {1'b0, push} - {1'b0, pop};
      end
   end

endmodule

// File: design/lrc_back.sv
module lrc_back import lrc_pkg::*; (
   input  logic                           clock,
   input  logic                           reset,
   input  cmd_type                        head,
   input  logic                           empty,
   output logic                           pop,
   output logic                           clearing,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic signed [SAMPLE_WIDTH-1:0] rsp_value,
   output logic [TIME_W-1:0]              rsp_time_index,
   output logic [BATCH_W-1:0]             rsp_batch_index,
   output logic [CHAN_W-1:0]              rsp_channel_index,
   output logic                           rsp_last
);

   logic signed [SAMPLE_WIDTH-1:0] tap_mem  [2**TAP_ADDR_W];
   logic signed [SAMPLE_WIDTH-1:0] hist_mem [2**HIST_ADDR_W];

   back_state_type state_ff, state_in;
   cmd_type        cmd_ff, cmd_in;
   logic [TAP_ADDR_W-1:0] clr_ff, clr_in;
   logic [TAP_W-1:0] k_ff, k_in, tau_ff, tau_in;
   logic issued_ff, issued_in;
   logic s1_ff, s2_ff, issue;
   logic signed [SAMPLE_WIDTH-1:0] hist_rd_ff, tap_rd_ff;
   logic signed [PROD_W-1:0] prod_ff;
   logic signed [ACC_W-1:0]  acc_ff;
   logic acc_clear;
   logic out_free, out_load;
   logic signed [ACC_W-SAMPLE_WIDTH:0] quot;
   logic signed [SAMPLE_WIDTH-1:0] sat;
   logic [TAP_W-1:0] rd_slot;

   logic tap_we;
   logic [TAP_ADDR_W-1:0] tap_waddr;
   logic signed [SAMPLE_WIDTH-1:0] tap_wdata;
   logic hist_we;

   assign out_free = !rsp_valid || !rsp_stall;
   assign clearing = (state_ff == BK_CLEAR);
   assign rd_slot  = cmd_ff.ring - (k_ff - tau_ff);

   always_comb begin
      state_in = state_ff;
      cmd_in = cmd_ff;
      clr_in = clr_ff;
      k_in = k_ff;
      tau_in = tau_ff;
      issued_in = issued_ff;
      pop = 1'b0;
      issue = 1'b0;
      acc_clear = 1'b0;
      out_load = 1'b0;
      tap_we = 1'b0;
      tap_waddr = clr_ff;
      tap_wdata = '0;
      hist_we = 1'b0;
      case (state_ff)
         BK_CLEAR: begin
            tap_we = 1'b1;
            clr_in = clr_ff + TAP_ADDR_W'(1);
            if (&clr_ff) state_in = BK_IDLE;
         end
         BK_IDLE: begin
            if (!empty) begin
               pop = 1'b1;
               cmd_in = head;
               if (head.is_coef) begin
                  tap_we = 1'b1;
                  tap_waddr = {head.tap_index, head.chan};
                  tap_wdata = head.coef;
               end else begin
                  hist_we = 1'b1;
                  k_in = head.k_first;
                  tau_in = '0;
                  issued_in = 1'b0;
                  acc_clear = 1'b1;
                  if (head.emit) state_in = BK_RUN;
               end
            end
         end
         BK_RUN: begin
            issue = !issued_ff;
            if (issue) begin
               tau_in = tau_ff + TAP_W'(1);
               if (tau_ff == k_ff) issued_in = 1'b1;
            end
            if (issued_ff && !s1_ff && !s2_ff) state_in = BK_DONE;
         end
         BK_DONE: begin
            if (out_free) begin
               out_load = 1'b1;
               if (k_ff == cmd_ff.k_last) begin
                  state_in = BK_IDLE;
               end else begin
                  k_in = k_ff - TAP_W'(1);
                  tau_in = '0;
                  issued_in = 1'b0;
                  acc_clear = 1'b1;
                  state_in = BK_RUN;
               end
            end
         end
         default: state_in = BK_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (tap_we) tap_mem[tap_waddr] <= tap_wdata;
      if (hist_we) hist_mem[{head.ring, head.batch, head.chan}] <= head.sample;
      hist_rd_ff <= hist_mem[{rd_slot, cmd_ff.batch, cmd_ff.chan}];
      tap_rd_ff  <= tap_mem[{tau_ff, cmd_ff.chan}];
      prod_ff    <= hist_rd_ff * tap_rd_ff;
      if (acc_clear) acc_ff <= '0;
      else if (s2_ff) acc_ff <= acc_ff + ACC_W'(prod_ff);
      cmd_ff <= cmd_in;
      k_ff   <= k_in;
      tau_ff <= tau_in;
   end

   // floor shift then clamp to the sample range
   always_comb begin
      quot = acc_ff[ACC_W-1:SAMPLE_WIDTH-1];
      if (quot > $signed({{(ACC_W-2*SAMPLE_WIDTH+2){1'b0}}, {(SAMPLE_WIDTH-1){1'b1}}}))
         sat = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
      else if (quot < $signed({{(ACC_W-2*SAMPLE_WIDTH+2){1'b1}}, {(SAMPLE_WIDTH-1){1'b0}}}))
         sat = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};
      else
         sat = quot[SAMPLE_WIDTH-1:0];
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_value         <= sat;
         rsp_time_index    <= cmd_ff.time_idx - TIME_W'(k_ff);
         rsp_batch_index   <= cmd_ff.batch;
         rsp_channel_index <= cmd_ff.chan;
         rsp_last          <= (k_ff == cmd_ff.k_last);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= BK_CLEAR;
         clr_ff    <= '0;
         issued_ff <= 1'b0;
         s1_ff     <= 1'b0;
         s2_ff     <= 1'b0;
         rsp_valid <= 1'b0;
      end else begin
         state_ff  <= state_in;
         clr_ff    <= clr_in;
         issued_ff <= issued_in;
         s1_ff     <= issue;
         s2_ff     <= s1_ff;
         if (out_load) rsp_valid <= 1'b1;
         else if (!rsp_stall) rsp_valid <= 1'b0;
      end
   end

endmodule

// File: design/lookahead_row_convolution_unit.sv
// channel  handshake          payload
// req      req_valid/stall    operation, tap_index, coef_channel, coefficient, sample,
//                             final_step
// rsp      rsp_valid/stall    value, time_index, batch_index, channel_index, last
// csr      csr_write_enable   csr_index, csr_write_data
// A coefficient write is stored straight from the back end's idle state. A sample emitting n results
// for lookahead depths k uses one shared multiplier, one tap a cycle.
// After reset all 1024 entries of the tap store are cleared; req_stall stays high meanwhile.
// A two-entry queue lets the front take requests while the back end works;
// rsp holds in its output register while rsp_stall is high.
module lookahead_row_convolution_unit import lrc_pkg::*; (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_write_enable,
   input  logic [1:0]                     csr_index,
   input  logic [6:0]                     csr_write_data,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic                           req_operation,
   input  logic [3:0]                     req_tap_index,
   input  logic [5:0]                     req_coef_channel,
   input  logic signed [15:0]             req_coefficient,
   input  logic signed [15:0]             req_sample,
   input  logic                           req_final_step,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic signed [15:0]             rsp_value,
   output logic [15:0]                    rsp_time_index,
   output logic [2:0]                     rsp_batch_index,
   output logic [5:0]                     rsp_channel_index,
   output logic                           rsp_last
);

   cmd_type cmd, head;
   logic accept, empty, full, pop, clearing;

   assign req_stall = full || clearing;
   assign accept = req_valid && !req_stall;

   lrc_front u_front (
      .clock, .reset, .csr_write_enable, .csr_index, .csr_write_data,
      .accept, .req_operation, .req_tap_index, .req_coef_channel,
      .req_coefficient, .req_sample, .req_final_step, .cmd
   );

   lrc_queue u_queue (
      .clock, .reset, .push(accept), .push_cmd(cmd), .pop, .head, .empty, .full
   );

   lrc_back u_back (
      .clock, .reset, .head, .empty, .pop, .clearing,
      .rsp_valid, .rsp_stall, .rsp_value, .rsp_time_index, .rsp_batch_index,
      .rsp_channel_index, .rsp_last
   );

endmodule

// File: design/lrc_checker.sv
`include "lookahead_row_convolution_unit_assert.svh"

module lrc_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [15:0] rsp_value,
   input logic [15:0] rsp_time_index,
   input logic        rsp_last
);

   `LRC_ASSERT_ALL(a_reset_no_rsp, reset |=> !rsp_valid, "response valid right after reset")
   `LRC_ASSERT_ALL(a_clear_stalls, $fell(reset) |-> req_stall, "request taken during clear")
   `LRC_ASSERT_RUN(a_rsp_hold,
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_value) &&
         $stable(rsp_time_index) && $stable(rsp_last),
      "stalled response changed")

endmodule

bind lookahead_row_convolution_unit lrc_checker u_lrc_checker (
   .clock, .reset, .req_stall, .rsp_valid, .rsp_stall, .rsp_value,
   .rsp_time_index, .rsp_last
);
